/* sv/ptsc_pkg.sv */
// Shared types, constants and the microcode table of the PWM timer setup calculator.
// No dependencies; the divider, the sequencer and the top level import this package.
package ptsc_pkg;

    localparam int STEP_W = 5;
    localparam int DVD_W  = 32;
    localparam int DVR_W  = 44;

    localparam logic [31:0] CLK_RESET = 32'd32000000;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ARG = 2'd1;
    localparam logic [1:0] ST_LOW = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_TOTAL,
        OP_MIN_TOTAL,
        OP_DIVIDER,
        OP_DIV_PRE,
        OP_PRESCALE,
        OP_MUL_DP,
        OP_MUL_FREQ,
        OP_DIV_LOAD,
        OP_COMMIT,
        OP_ERR_ARG,
        OP_ERR_LOW,
        OP_DUTY,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_ITEM,
        C_DUTY,
        C_BAD,
        C_BUSY,
        C_LOW,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic no_item;
        logic duty_item;
        logic bad_freq;
        logic div_busy;
        logic too_low;
        logic out_full;
    } flags_t;

    localparam step_t S_IDLE    = 5'd0;
    localparam step_t S_DISP    = 5'd1;
    localparam step_t S_CHECK   = 5'd2;
    localparam step_t S_DTOT    = 5'd3;
    localparam step_t S_WTOT    = 5'd4;
    localparam step_t S_MT      = 5'd5;
    localparam step_t S_DV      = 5'd6;
    localparam step_t S_TSTLOW  = 5'd7;
    localparam step_t S_DPRE    = 5'd8;
    localparam step_t S_WPRE    = 5'd9;
    localparam step_t S_PR      = 5'd10;
    localparam step_t S_MDP     = 5'd11;
    localparam step_t S_MFREQ   = 5'd12;
    localparam step_t S_DLOAD   = 5'd13;
    localparam step_t S_WLOAD   = 5'd14;
    localparam step_t S_COMMIT  = 5'd15;
    localparam step_t S_ERR_ARG = 5'd16;
    localparam step_t S_ERR_LOW = 5'd17;
    localparam step_t S_DUTY    = 5'd18;
    localparam step_t S_EMIT    = 5'd19;
    localparam step_t S_RET     = 5'd20;

    // Control word per step: a taken condition jumps to target, else fall through.
    function automatic ctrl_t rom_word(step_t addr);
        ctrl_t w;
        case (addr)
            S_IDLE:    w = '{OP_LOAD,      C_NO_ITEM,  S_IDLE};
            S_DISP:    w = '{OP_NOP,       C_DUTY,     S_DUTY};
            S_CHECK:   w = '{OP_NOP,       C_BAD,      S_ERR_ARG};
            S_DTOT:    w = '{OP_DIV_TOTAL, C_NONE,     S_IDLE};
            S_WTOT:    w = '{OP_NOP,       C_BUSY,     S_WTOT};
            S_MT:      w = '{OP_MIN_TOTAL, C_NONE,     S_IDLE};
            S_DV:      w = '{OP_DIVIDER,   C_NONE,     S_IDLE};
            S_TSTLOW:  w = '{OP_NOP,       C_LOW,      S_ERR_LOW};
            S_DPRE:    w = '{OP_DIV_PRE,   C_NONE,     S_IDLE};
            S_WPRE:    w = '{OP_NOP,       C_BUSY,     S_WPRE};
            S_PR:      w = '{OP_PRESCALE,  C_NONE,     S_IDLE};
            S_MDP:     w = '{OP_MUL_DP,    C_NONE,     S_IDLE};
            S_MFREQ:   w = '{OP_MUL_FREQ,  C_NONE,     S_IDLE};
            S_DLOAD:   w = '{OP_DIV_LOAD,  C_NONE,     S_IDLE};
            S_WLOAD:   w = '{OP_NOP,       C_BUSY,     S_WLOAD};
            S_COMMIT:  w = '{OP_COMMIT,    C_ALWAYS,   S_EMIT};
            S_ERR_ARG: w = '{OP_ERR_ARG,   C_ALWAYS,   S_EMIT};
            S_ERR_LOW: w = '{OP_ERR_LOW,   C_ALWAYS,   S_EMIT};
            S_DUTY:    w = '{OP_DUTY,      C_NONE,     S_IDLE};
            S_EMIT:    w = '{OP_EMIT,      C_OUT_FULL, S_EMIT};
            S_RET:     w = '{OP_NOP,       C_ALWAYS,   S_IDLE};
            default:   w = '{OP_NOP,       C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* sv/ptsc_ifs.sv */
// Valid/ready channel interfaces for the request and result transactions.
// Depends on nothing; used by the top level ports.
interface ptsc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] frequency_hz;
    logic [16:0] duty;

    modport source (output valid, output action, output frequency_hz, output duty,
                    input ready);
    modport sink   (input valid, input action, input frequency_hz, input duty,
                    output ready);
endinterface

interface ptsc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  clock_divide_code;
    logic [7:0]  prescale_code;
    logic [15:0] period_load;
    logic [16:0] match_value;

    modport source (output valid, output status, output clock_divide_code,
                    output prescale_code, output period_load, output match_value,
                    input ready);
    modport sink   (input valid, input status, input clock_divide_code,
                    input prescale_code, input period_load, input match_value,
                    output ready);
endinterface

/* sv/ptsc_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on ptsc_pkg for operand widths.
module ptsc_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ptsc_pkg::DVD_W-1:0] dividend,
    input  logic [ptsc_pkg::DVR_W-1:0] divisor,
    output logic                      busy,
    output logic [ptsc_pkg::DVD_W-1:0] quotient
);
    import ptsc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVR_W-1:0] rem_reg;
    logic [DVR_W-1:0] dvr_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVR_W:0]   shifted;
    logic             fits;
    logic [DVR_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvr_reg};
    assign diff    = shifted - {1'b0, dvr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W - 1);
        end
        else if (busy_reg)
        begin
            // drop busy after the last quotient bit
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVR_W-1:0] : shifted[DVR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* sv/ptsc_seq.sv */
// Microcode sequencer: step counter, control-word table and jump logic.
// Depends on ptsc_pkg for the control word, flags and the program table.
module ptsc_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  ptsc_pkg::flags_t flags,
    output ptsc_pkg::ctrl_t  ctrl
);
    import ptsc_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  taken;

    always_comb
    begin
        ctrl = rom_word(step_reg);
        case (ctrl.cond)
            C_NONE:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_ITEM:  taken = flags.no_item;
            C_DUTY:     taken = flags.duty_item;
            C_BAD:      taken = flags.bad_freq;
            C_BUSY:     taken = flags.div_busy;
            C_LOW:      taken = flags.too_low;
            C_OUT_FULL: taken = flags.out_full;
            default:    taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* sv/pwm_timer_setup_calculator.sv */
// A frequency transaction makes three passes through the shared serial divider; a frequency
// below range makes one, and an argument error or a duty transaction makes none.
// One transaction at a time: once the result is registered the sequencer steps through S_RET
// back to S_IDLE and takes the next, even while that result still waits on the output.
// Reset clears the kept divider, prescaler and load and sets the clock register to 32000000.
module pwm_timer_setup_calculator
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    ptsc_in_if.sink           in_ch,
    ptsc_out_if.source        out_ch
);
    import ptsc_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    logic        div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVR_W-1:0] div_divisor;
    logic        div_busy;
    logic [DVD_W-1:0] div_q;

    logic [31:0] clk_reg;
    logic        act_reg;
    logic [31:0] freq_reg;
    logic [16:0] duty_reg;
    logic [16:0] mt_reg;
    logic [8:0]  dv_reg;
    logic [8:0]  pr_reg;
    logic [11:0] dp_reg;
    logic [DVR_W-1:0] prod_reg;
    logic [1:0]  status_reg;
    logic [16:0] cmp_reg;
    logic [2:0]  divide_reg;
    logic [7:0]  prescale_reg;
    logic [15:0] load_reg;

    logic        out_valid_reg;
    logic [1:0]  o_status_reg;
    logic [2:0]  o_div_reg;
    logic [7:0]  o_pre_reg;
    logic [15:0] o_load_reg;
    logic [16:0] o_cmp_reg;

    logic        accept;
    logic        emit_fire;
    logic [32:0] mt_sum;
    logic [16:0] mt_val;
    logic [16:0] dv_sum;
    logic [8:0]  dv_val;
    logic [8:0]  pr_val;
    logic [12:0] dp_full;
    logic [DVR_W-1:0] prod_full;
    logic [31:0] load_m1;
    logic [15:0] load_val;
    logic [16:0] duty_comp;
    logic [32:0] duty_mul;
    logic [16:0] cmp_val;

    ptsc_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    ptsc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign in_ch.ready = (ctrl.op == OP_LOAD);
    assign accept      = in_ch.valid && in_ch.ready;

    assign flags.no_item   = !in_ch.valid;
    assign flags.duty_item = act_reg;
    assign flags.bad_freq  = (freq_reg == 32'd0) || (freq_reg > clk_reg);
    assign flags.div_busy  = div_busy;
    assign flags.too_low   = dv_reg > 9'd8;
    assign flags.out_full  = out_valid_reg && !out_ch.ready;

    assign emit_fire = (ctrl.op == OP_EMIT) && !flags.out_full;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = clk_reg;
        div_divisor  = DVR_W'(freq_reg);
        case (ctrl.op)
            OP_DIV_TOTAL:
            begin
                div_start = 1'b1;
            end
            OP_DIV_PRE:
            begin
                div_start    = 1'b1;
                div_dividend = 32'(mt_reg) + 32'(dv_reg) - 32'd1;
                div_divisor  = DVR_W'(dv_reg);
            end
            OP_DIV_LOAD:
            begin
                div_start   = 1'b1;
                div_divisor = prod_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // least total prescale, divider, prescaler, product and load arithmetic
    always_comb
    begin
        mt_sum = {1'b0, div_q} + 33'd65535;
        mt_val = (mt_sum[32:16] == 17'd0) ? 17'd1 : mt_sum[32:16];
        dv_sum = mt_reg + 17'd255;
        dv_val = (dv_sum[16:8] == 9'd0) ? 9'd1 : dv_sum[16:8];
        if (div_q == 32'd0)
        begin
            pr_val = 9'd1;
        end
        else if (div_q > 32'd256)
        begin
            pr_val = 9'd256;
        end
        else
        begin
            pr_val = div_q[8:0];
        end
        dp_full   = {9'd0, dv_reg[3:0]} * {4'd0, pr_reg};
        prod_full = DVR_W'(freq_reg) * DVR_W'(dp_reg);
        load_m1   = (div_q == 32'd0) ? 32'd0 : div_q - 32'd1;
        load_val  = (load_m1 > 32'd65535) ? 16'hFFFF : load_m1[15:0];
    end

    // compare value from the kept load
    always_comb
    begin
        duty_comp = 17'd65536 - duty_reg;
        duty_mul  = {17'd0, load_reg} * {16'd0, duty_comp};
        if (duty_reg == 17'd0)
        begin
            cmp_val = {1'b0, load_reg};
        end
        else if (duty_reg[16])
        begin
            cmp_val = {1'b0, load_reg} + 17'd1;
        end
        else
        begin
            cmp_val = duty_mul[32:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_reg       <= CLK_RESET;
            divide_reg    <= '0;
            prescale_reg  <= '0;
            load_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                clk_reg <= cfg_wdata;
            end
            if (ctrl.op == OP_COMMIT)
            begin
                divide_reg   <= 3'(dv_reg - 9'd1);
                prescale_reg <= 8'(pr_reg - 9'd1);
                load_reg     <= load_val;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= in_ch.action;
            freq_reg <= in_ch.frequency_hz;
            duty_reg <= in_ch.duty;
        end
        case (ctrl.op)
            OP_MIN_TOTAL: mt_reg   <= mt_val;
            OP_DIVIDER:   dv_reg   <= dv_val;
            OP_PRESCALE:  pr_reg   <= pr_val;
            OP_MUL_DP:    dp_reg   <= dp_full[11:0];
            OP_MUL_FREQ:  prod_reg <= prod_full;
            OP_COMMIT:
            begin
                status_reg <= ST_OK;
                cmp_reg    <= '0;
            end
            OP_ERR_ARG:
            begin
                status_reg <= ST_ARG;
                cmp_reg    <= '0;
            end
            OP_ERR_LOW:
            begin
                status_reg <= ST_LOW;
                cmp_reg    <= '0;
            end
            OP_DUTY:
            begin
                status_reg <= ST_OK;
                cmp_reg    <= cmp_val;
            end
            default:
            begin
                status_reg <= status_reg;
            end
        endcase
        // hold the result until the sink takes the transaction
        if (emit_fire)
        begin
            o_status_reg <= status_reg;
            o_div_reg    <= divide_reg;
            o_pre_reg    <= prescale_reg;
            o_load_reg   <= load_reg;
            o_cmp_reg    <= cmp_reg;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.status            = o_status_reg;
    assign out_ch.clock_divide_code = o_div_reg;
    assign out_ch.prescale_code     = o_pre_reg;
    assign out_ch.period_load       = o_load_reg;
    assign out_ch.match_value       = o_cmp_reg;

endmodule
